@@ hw/rtl/ptg_pkg.sv @@
// shared constants, types and register codes of the perlin turbulence generator
package ptg_pkg;

  localparam int LATTICE_SIZE   = 256;
  localparam int LAT_W          = $clog2(LATTICE_SIZE);
  localparam int NUM_CH         = 4;
  localparam int CH_W           = $clog2(NUM_CH);
  localparam int GRAD_DEPTH     = NUM_CH * LATTICE_SIZE;
  localparam int GRAD_AW        = CH_W + LAT_W;
  localparam int LATTICE_OFFSET = 4096;
  localparam int COORD_BITS     = 12;
  localparam int FREQ_W         = 20;
  localparam int TILE_W         = 13;
  localparam int MAX_OCTAVES    = 10;
  localparam int OCT_W          = 4;
  localparam int FRAC_BITS      = 16;
  localparam int VEC_W          = COORD_BITS + FREQ_W + MAX_OCTAVES - 1;
  localparam int SW_W           = 18;
  localparam int WK_W           = SW_W + MAX_OCTAVES - 1;
  localparam int LC_W           = 28;
  localparam int NS_W           = 19;
  localparam int PIX_W          = 8;
  localparam int SUM_W          = 24;

  localparam logic [30:0] PM_M     = 31'h7FFF_FFFF;
  localparam logic [30:0] SEED_MAX = 31'h7FFF_FFFE;
  localparam logic [14:0] PM_A     = 15'd16807;

  typedef enum logic [2:0] {
    CFG_SEED,
    CFG_FREQ_X,
    CFG_FREQ_Y,
    CFG_OCTAVES,
    CFG_FRACTAL,
    CFG_STITCH,
    CFG_TILE_W,
    CFG_TILE_H
  } cfg_idx_t;

  typedef enum logic {
    OP_BUILD = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [31:0] seed;
    logic [FREQ_W-1:0]  freq_x;
    logic [FREQ_W-1:0]  freq_y;
    logic [OCT_W-1:0]   octaves;
    logic               fractal_sum;
    logic               stitch_tiles;
    logic [TILE_W-1:0]  tile_width;
    logic [TILE_W-1:0]  tile_height;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] adj_fx;
    logic [FREQ_W-1:0] adj_fy;
    logic [SW_W-1:0]   wx;
    logic [SW_W-1:0]   wy;
  } geom_t;

  typedef struct packed {
    logic               perm_we;
    logic [LAT_W-1:0]   perm_waddr;
    logic [LAT_W-1:0]   perm_wdata;
    logic [LAT_W-1:0]   perm_raddr;
    logic               grad_we;
    logic [GRAD_AW-1:0] grad_waddr;
    logic [31:0]        grad_wdata;
  } bmem_t;

  typedef struct packed {
    logic signed [NS_W-1:0] noise_sum;
    logic [PIX_W-1:0]       pixel_value;
  } res_t;

endpackage

@@ hw/rtl/ptg_ram.sv @@
// generic single write port ram with registered read
module ptg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

@@ hw/rtl/ptg_build.sv @@
// table build sequencer: generator, gradient normalizer, shuffle and stitch fit
module ptg_build (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  ptg_pkg::cfg_t             cfg,
  input  logic [ptg_pkg::LAT_W-1:0] perm_rdata,
  output ptg_pkg::bmem_t            mem,
  output ptg_pkg::geom_t            geom,
  output logic                      busy,
  output logic                      done
);
  import ptg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_MUL, S_RED, S_CAPX, S_CAPY, S_NSQ, S_NCMP, S_WRITE,
    S_SH_RDI, S_SH_RDJ, S_SH_WI, S_SH_WJ,
    S_FIT_P, S_FIT_M, S_FIT_N, S_FIT_DIV, S_FIT_ST, S_DONE
  } state_t;

  state_t state, ret;
  logic [30:0] s;
  logic [45:0] prod;
  logic [CH_W-1:0] chan;
  logic [LAT_W-1:0] idx, tmp;
  logic signed [9:0] cx, cy;
  logic [17:0] nrm;
  logic sel;
  logic [15:0] r, gx;
  logic [3:0] bpos;
  logic [33:0] sq;
  logic axis;
  logic [TILE_W-1:0] wreg;
  logic [32:0] pval;
  logic [32:0] lr;
  logic [31:0] rsq;
  logic [SW_W-1:0] nfit;
  logic [33:0] num;
  logic [TILE_W-1:0] rem;
  logic [5:0] dcnt;

  function automatic logic [30:0] pm_reduce(input logic [45:0] p);
    logic [31:0] t;
    t = {1'b0, p[30:0]} + {17'd0, p[45:31]};
    if (t >= {1'b0, PM_M}) begin
      t = t - {1'b0, PM_M};
    end
    return t[30:0];
  endfunction

  function automatic logic [15:0] sgn_comp(input logic signed [9:0] c,
                                           input logic [17:0] n,
                                           input logic [15:0] v);
    if (n == '0) begin
      return '0;
    end
    return c[9] ? 16'(-v) : v;
  endfunction

  // seed clamp
  logic [32:0] sneg, sneg_m;
  logic [30:0] seed_c;
  always_comb begin
    sneg   = 33'd0 - {cfg.seed[31], cfg.seed};
    sneg_m = (sneg >= {2'b0, SEED_MAX}) ? sneg - {2'b0, SEED_MAX} : sneg;
    if (cfg.seed[31] || cfg.seed == '0) begin
      seed_c = sneg_m[30:0] + 31'd1;
    end else if (cfg.seed[30:0] > SEED_MAX) begin
      seed_c = SEED_MAX;
    end else begin
      seed_c = cfg.seed[30:0];
    end
  end

  // normalizer step
  logic signed [9:0] cy_w, csel;
  logic [9:0] aval;
  logic [46:0] lim;
  logic [16:0] dtrial;
  logic [15:0] bitm, r_new;
  always_comb begin
    cy_w   = $signed({1'b0, s[8:0]}) - 10'sd256;
    csel   = sel ? cy : cx;
    aval   = csel[9] ? 10'(-csel) : csel;
    lim    = {20'(aval * aval), 27'd0} << 3;
    bitm   = 16'd1 << bpos;
    dtrial = {(r | bitm), 1'b0} - 17'd1;
    r_new  = (52'(sq * nrm) <= 52'(lim)) ? (r | bitm) : r;
  end

  // stitch fit
  logic [TILE_W-1:0] wsel;
  logic [FREQ_W-1:0] fsel;
  logic [16:0] flo;
  logic [15:0] frem;
  logic [17:0] nsel;
  logic [13:0] trial;
  always_comb begin
    wsel = axis ? cfg.tile_height : cfg.tile_width;
    if (wsel == '0) begin
      wsel = TILE_W'(1);
    end
    fsel  = axis ? cfg.freq_y : cfg.freq_x;
    flo   = pval[32:16];
    frem  = pval[15:0];
    nsel  = (frem == '0 || (51'({lr, 17'd0}) + 51'(rsq) < 51'({flo, 32'd0})))
            ? {1'b0, flo} : {1'b0, flo} + 18'd1;
    trial = {rem, num[33]};
  end

  always_comb begin
    mem            = '0;
    mem.perm_raddr = idx;
    unique case (state)
      S_WRITE: begin
        mem.grad_we    = 1'b1;
        mem.grad_waddr = {chan, idx};
        mem.grad_wdata = {sgn_comp(cy, nrm, r), gx};
        mem.perm_we    = (chan == '0);
        mem.perm_waddr = idx;
        mem.perm_wdata = idx;
      end
      S_SH_RDJ: mem.perm_raddr = s[LAT_W-1:0];
      S_SH_WI: begin
        mem.perm_we    = 1'b1;
        mem.perm_waddr = idx;
        mem.perm_wdata = perm_rdata;
      end
      S_SH_WJ: begin
        mem.perm_we    = 1'b1;
        mem.perm_waddr = s[LAT_W-1:0];
        mem.perm_wdata = tmp;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      geom  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SEED;
          end
        end
        S_SEED: begin
          s     <= seed_c;
          chan  <= '0;
          idx   <= '0;
          ret   <= S_CAPX;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 46'(s * PM_A);
          state <= S_RED;
        end
        S_RED: begin
          s     <= pm_reduce(prod);
          state <= ret;
        end
        S_CAPX: begin
          cx    <= cy_w;
          ret   <= S_CAPY;
          state <= S_MUL;
        end
        S_CAPY: begin
          cy    <= cy_w;
          nrm   <= 18'(cx * cx) + 18'(cy_w * cy_w);
          sel   <= 1'b0;
          r     <= '0;
          bpos  <= 4'd15;
          state <= S_NSQ;
        end
        S_NSQ: begin
          sq    <= 34'(dtrial * dtrial);
          state <= S_NCMP;
        end
        S_NCMP: begin
          if (bpos == '0) begin
            if (!sel) begin
              gx    <= sgn_comp(cx, nrm, r_new);
              sel   <= 1'b1;
              r     <= '0;
              bpos  <= 4'd15;
              state <= S_NSQ;
            end else begin
              r     <= r_new;
              state <= S_WRITE;
            end
          end else begin
            r     <= r_new;
            bpos  <= bpos - 4'd1;
            state <= S_NSQ;
          end
        end
        S_WRITE: begin
          state <= S_MUL;
          if (idx == LAT_W'(LATTICE_SIZE - 1)) begin
            if (chan == CH_W'(NUM_CH - 1)) begin
              ret <= S_SH_RDI;
            end else begin
              chan <= chan + CH_W'(1);
              idx  <= '0;
              ret  <= S_CAPX;
            end
          end else begin
            idx <= idx + LAT_W'(1);
            ret <= S_CAPX;
          end
        end
        S_SH_RDI: state <= S_SH_RDJ;
        S_SH_RDJ: begin
          tmp   <= perm_rdata;
          state <= S_SH_WI;
        end
        S_SH_WI: state <= S_SH_WJ;
        S_SH_WJ: begin
          if (idx == LAT_W'(1)) begin
            axis <= 1'b0;
            if (cfg.stitch_tiles) begin
              state <= S_FIT_P;
            end else begin
              geom.adj_fx <= cfg.freq_x;
              geom.adj_fy <= cfg.freq_y;
              geom.wx     <= '0;
              geom.wy     <= '0;
              state       <= S_DONE;
            end
          end else begin
            idx   <= idx - LAT_W'(1);
            ret   <= S_SH_RDI;
            state <= S_MUL;
          end
        end
        S_FIT_P: begin
          wreg  <= wsel;
          pval  <= 33'(wsel * fsel);
          state <= S_FIT_M;
        end
        S_FIT_M: begin
          lr    <= 33'(flo * frem);
          rsq   <= 32'(frem * frem);
          state <= S_FIT_N;
        end
        S_FIT_N: begin
          nfit  <= nsel;
          num   <= {nsel[17:0], 16'd0} + 34'(wreg >> 1);
          rem   <= '0;
          dcnt  <= 6'd33;
          state <= S_FIT_DIV;
        end
        S_FIT_DIV: begin
          if (trial >= {1'b0, wreg}) begin
            rem <= TILE_W'(trial - {1'b0, wreg});
            num <= {num[32:0], 1'b1};
          end else begin
            rem <= trial[TILE_W-1:0];
            num <= {num[32:0], 1'b0};
          end
          if (dcnt == '0) begin
            state <= S_FIT_ST;
          end else begin
            dcnt <= dcnt - 6'd1;
          end
        end
        S_FIT_ST: begin
          if (!axis) begin
            geom.adj_fx <= (num > 34'hF_FFFF) ? '1 : num[FREQ_W-1:0];
            geom.wx     <= nfit;
            axis        <= 1'b1;
            state       <= S_FIT_P;
          end else begin
            geom.adj_fy <= (num > 34'hF_FFFF) ? '1 : num[FREQ_W-1:0];
            geom.wy     <= nfit;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          geom.valid <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/ptg_eval.sv @@
// octave sequencer: lattice lookups, gradient dots, smooth lerps and sum
module ptg_eval (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  ptg_pkg::cfg_t                  cfg,
  input  ptg_pkg::geom_t                 geom,
  input  logic [ptg_pkg::COORD_BITS-1:0] pos_x,
  input  logic [ptg_pkg::COORD_BITS-1:0] pos_y,
  input  logic [ptg_pkg::CH_W-1:0]       channel,
  input  logic [ptg_pkg::LAT_W-1:0]      perm_rdata,
  input  logic [31:0]                    grad_rdata,
  output logic [ptg_pkg::LAT_W-1:0]      perm_raddr,
  output logic [ptg_pkg::GRAD_AW-1:0]    grad_raddr,
  output logic                           busy,
  output logic                           done,
  output ptg_pkg::res_t                  res
);
  import ptg_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE, E_VEC, E_COORD, E_P0, E_P1, E_P2, E_P3, E_P4, E_P5, E_P6,
    E_G1, E_G2, E_G3, E_G4, E_L1, E_L2, E_L3, E_L4, E_DONE
  } state_t;

  state_t state;
  logic [COORD_BITS-1:0] px, py;
  logic [CH_W-1:0] chan;
  logic [VEC_W-1:0] vx, vy;
  logic [WK_W-1:0] wxk, wyk;
  logic [OCT_W-1:0] kk, noct;
  logic [LAT_W-1:0] ix0, ix1, iy0, iy1, pi, pj, h00, h01, h10, h11;
  logic [15:0] rx0, ry0, tsqx, tsqy;
  logic [16:0] sx, sy;
  logic signed [19:0] d00, d01, d10, d11, a, b;
  logic signed [38:0] la, lb;
  logic signed [SUM_W-1:0] sum;

  function automatic logic signed [19:0] dotp(input logic [31:0] g,
                                               input logic signed [16:0] rx,
                                               input logic signed [16:0] ry);
    logic signed [33:0] p;
    p = 34'(rx * $signed(g[15:0])) + 34'(ry * $signed(g[31:16]));
    return 20'(p >>> 14);
  endfunction

  logic signed [16:0] srx0, srx1, sry0, sry1;
  assign srx0 = $signed({1'b0, rx0});
  assign srx1 = $signed({1'b1, rx0});
  assign sry0 = $signed({1'b0, ry0});
  assign sry1 = $signed({1'b1, ry0});

  // lattice cell with tile wrap
  logic [LC_W-1:0] bx0, bx1, by0, by1, wrx, wry;
  always_comb begin
    bx0 = LC_W'(vx[VEC_W-1:FRAC_BITS]) + LC_W'(LATTICE_OFFSET);
    by0 = LC_W'(vy[VEC_W-1:FRAC_BITS]) + LC_W'(LATTICE_OFFSET);
    bx1 = bx0 + LC_W'(1);
    by1 = by0 + LC_W'(1);
    wrx = LC_W'(wxk) + LC_W'(LATTICE_OFFSET);
    wry = LC_W'(wyk) + LC_W'(LATTICE_OFFSET);
    if (cfg.stitch_tiles) begin
      if (bx0 >= wrx) bx0 = bx0 - LC_W'(wxk);
      if (bx1 >= wrx) bx1 = bx1 - LC_W'(wxk);
      if (by0 >= wry) by0 = by0 - LC_W'(wyk);
      if (by1 >= wry) by1 = by1 - LC_W'(wyk);
    end
  end

  logic signed [19:0] nval, nabs, term;
  always_comb begin
    nval = a + 20'(la >>> FRAC_BITS);
    nabs = nval[19] ? -nval : nval;
    term = cfg.fractal_sum ? (nval >>> kk) : (nabs >>> kk);
  end

  always_comb begin
    unique case (state)
      E_P1:    perm_raddr = ix1;
      E_P2:    perm_raddr = pi + iy0;
      E_P3:    perm_raddr = pi + iy1;
      E_P4:    perm_raddr = pj + iy0;
      E_P5:    perm_raddr = pj + iy1;
      default: perm_raddr = ix0;
    endcase
    unique case (state)
      E_G1:    grad_raddr = {chan, h10};
      E_G2:    grad_raddr = {chan, h01};
      E_G3:    grad_raddr = {chan, h11};
      default: grad_raddr = {chan, h00};
    endcase
  end

  // saturation and byte mapping
  logic signed [NS_W-1:0] s16;
  logic signed [27:0] pp, pv;
  always_comb begin
    if (sum > SUM_W'(262143)) begin
      s16 = NS_W'(262143);
    end else if (sum < -SUM_W'(262144)) begin
      s16 = -NS_W'(262144);
    end else begin
      s16 = sum[NS_W-1:0];
    end
    pp = 28'(s16 * 9'sd255);
    pv = cfg.fractal_sum ? ((pp + 28'sd16711680) >>> 17) : (pp >>> 16);
    res.noise_sum = s16;
    if (pv < 0) begin
      res.pixel_value = '0;
    end else if (pv > 28'sd255) begin
      res.pixel_value = '1;
    end else begin
      res.pixel_value = pv[PIX_W-1:0];
    end
  end

  assign busy = (state != E_IDLE);
  assign done = (state == E_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (start) begin
            px    <= pos_x;
            py    <= pos_y;
            chan  <= channel;
            state <= E_VEC;
          end
        end
        E_VEC: begin
          vx   <= VEC_W'(px * geom.adj_fx);
          vy   <= VEC_W'(py * geom.adj_fy);
          wxk  <= WK_W'(geom.wx);
          wyk  <= WK_W'(geom.wy);
          kk   <= '0;
          sum  <= '0;
          noct <= (cfg.octaves > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : cfg.octaves;
          state <= (cfg.octaves == '0) ? E_DONE : E_COORD;
        end
        E_COORD: begin
          ix0   <= bx0[LAT_W-1:0];
          ix1   <= bx1[LAT_W-1:0];
          iy0   <= by0[LAT_W-1:0];
          iy1   <= by1[LAT_W-1:0];
          rx0   <= vx[FRAC_BITS-1:0];
          ry0   <= vy[FRAC_BITS-1:0];
          state <= E_P0;
        end
        E_P0: begin
          tsqx  <= 16'(32'(rx0 * rx0) >> FRAC_BITS);
          tsqy  <= 16'(32'(ry0 * ry0) >> FRAC_BITS);
          state <= E_P1;
        end
        E_P1: begin
          pi    <= perm_rdata;
          sx    <= 17'(34'(tsqx * (18'd196608 - {1'b0, rx0, 1'b0})) >> FRAC_BITS);
          sy    <= 17'(34'(tsqy * (18'd196608 - {1'b0, ry0, 1'b0})) >> FRAC_BITS);
          state <= E_P2;
        end
        E_P2: begin
          pj    <= perm_rdata;
          state <= E_P3;
        end
        E_P3: begin
          h00   <= perm_rdata;
          state <= E_P4;
        end
        E_P4: begin
          h01   <= perm_rdata;
          state <= E_P5;
        end
        E_P5: begin
          h10   <= perm_rdata;
          state <= E_P6;
        end
        E_P6: begin
          h11   <= perm_rdata;
          state <= E_G1;
        end
        E_G1: begin
          d00   <= dotp(grad_rdata, srx0, sry0);
          state <= E_G2;
        end
        E_G2: begin
          d10   <= dotp(grad_rdata, srx1, sry0);
          state <= E_G3;
        end
        E_G3: begin
          d01   <= dotp(grad_rdata, srx0, sry1);
          state <= E_G4;
        end
        E_G4: begin
          d11   <= dotp(grad_rdata, srx1, sry1);
          state <= E_L1;
        end
        E_L1: begin
          la    <= 39'($signed({1'b0, sx}) * (21'(d10) - 21'(d00)));
          lb    <= 39'($signed({1'b0, sx}) * (21'(d11) - 21'(d01)));
          state <= E_L2;
        end
        E_L2: begin
          a     <= d00 + 20'(la >>> FRAC_BITS);
          b     <= d01 + 20'(lb >>> FRAC_BITS);
          state <= E_L3;
        end
        E_L3: begin
          la    <= 39'($signed({1'b0, sy}) * (21'(b) - 21'(a)));
          state <= E_L4;
        end
        E_L4: begin
          sum <= sum + SUM_W'(term);
          kk  <= kk + OCT_W'(1);
          vx  <= vx << 1;
          vy  <= vy << 1;
          wxk <= wxk << 1;
          wyk <= wyk << 1;
          state <= (kk + OCT_W'(1) == noct) ? E_DONE : E_COORD;
        end
        E_DONE: state <= E_IDLE;
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/perlin_turbulence_generator.sv @@
// top level of the perlin turbulence generator
//
//  port group   dir  content
//  s_t*         in   beat: op in tuser, pos_x / pos_y / channel in tdata
//  m_t*         out  beat: noise_sum / pixel_value in tdata
//  cfg_*        in   register write, index 0..7, no read-back
//
//  a table build makes 1024 gradients (16-step square-root search per component),
//  then does the shuffle swaps and, with stitching on, the stitch fit
//  a pixel's time is set by the single read port of the permutation memory
//  (six lookups per octave) and that of the gradient memory
//  one item at a time; the next beat is taken once the result sits in the
//  output register, a stalled output holds only the finished result
//  memories need no clearing after reset; a pixel before any build gives zero
module perlin_turbulence_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pos_x, pos_y, channel
  input  logic [0:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // noise_sum, pixel_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import ptg_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_BUILD, T_EVAL, T_OUT} state_t;

  state_t state;
  cfg_t cfg;
  geom_t geom;
  bmem_t bmem;
  res_t eval_res, res_hold;
  logic build_busy, build_done, eval_busy, eval_done;
  logic build_start, eval_start, out_load;
  logic [LAT_W-1:0] perm_rdata, eval_perm_raddr, perm_raddr;
  logic [GRAD_AW-1:0] eval_grad_raddr;
  logic [31:0] grad_rdata;

  assign s_tready    = (state == T_IDLE);
  assign build_start = s_tready && s_tvalid && (op_t'(s_tuser[0]) == OP_BUILD);
  assign eval_start  = s_tready && s_tvalid && (op_t'(s_tuser[0]) == OP_EVAL) && geom.valid;
  assign out_load    = (state == T_OUT) && (!m_tvalid || m_tready);
  assign perm_raddr  = (state == T_BUILD) ? bmem.perm_raddr : eval_perm_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed         <= '0;
      cfg.freq_x       <= FREQ_W'(655);
      cfg.freq_y       <= FREQ_W'(655);
      cfg.octaves      <= OCT_W'(1);
      cfg.fractal_sum  <= 1'b1;
      cfg.stitch_tiles <= 1'b0;
      cfg.tile_width   <= TILE_W'(256);
      cfg.tile_height  <= TILE_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SEED:    cfg.seed         <= $signed(cfg_wdata);
        CFG_FREQ_X:  cfg.freq_x       <= cfg_wdata[FREQ_W-1:0];
        CFG_FREQ_Y:  cfg.freq_y       <= cfg_wdata[FREQ_W-1:0];
        CFG_OCTAVES: cfg.octaves      <= cfg_wdata[OCT_W-1:0];
        CFG_FRACTAL: cfg.fractal_sum  <= cfg_wdata[0];
        CFG_STITCH:  cfg.stitch_tiles <= cfg_wdata[0];
        CFG_TILE_W:  cfg.tile_width   <= cfg_wdata[TILE_W-1:0];
        CFG_TILE_H:  cfg.tile_height  <= cfg_wdata[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (build_start) begin
            state <= T_BUILD;
          end else if (eval_start) begin
            state <= T_EVAL;
          end else if (s_tvalid) begin
            res_hold <= '0;
            state    <= T_OUT;
          end
        end
        T_BUILD: begin
          if (build_done) begin
            res_hold <= '0;
            state    <= T_OUT;
          end
        end
        T_EVAL: begin
          if (eval_done) begin
            res_hold <= eval_res;
            state    <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            m_tdata  <= {5'd0, res_hold.pixel_value, res_hold.noise_sum};
            m_tvalid <= 1'b1;
            state    <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  ptg_ram #(.WIDTH(LAT_W), .DEPTH(LATTICE_SIZE)) u_perm_ram (
    .clk   (clk),
    .we    (bmem.perm_we),
    .waddr (bmem.perm_waddr),
    .wdata (bmem.perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  ptg_ram #(.WIDTH(32), .DEPTH(GRAD_DEPTH)) u_grad_ram (
    .clk   (clk),
    .we    (bmem.grad_we),
    .waddr (bmem.grad_waddr),
    .wdata (bmem.grad_wdata),
    .raddr (eval_grad_raddr),
    .rdata (grad_rdata)
  );

  ptg_build u_build (
    .clk        (clk),
    .rst        (rst),
    .start      (build_start),
    .cfg        (cfg),
    .perm_rdata (perm_rdata),
    .mem        (bmem),
    .geom       (geom),
    .busy       (build_busy),
    .done       (build_done)
  );

  ptg_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .start      (eval_start),
    .cfg        (cfg),
    .geom       (geom),
    .pos_x      (s_tdata[11:0]),
    .pos_y      (s_tdata[23:12]),
    .channel    (s_tdata[25:24]),
    .perm_rdata (perm_rdata),
    .grad_rdata (grad_rdata),
    .perm_raddr (eval_perm_raddr),
    .grad_raddr (eval_grad_raddr),
    .busy       (eval_busy),
    .done       (eval_done),
    .res        (eval_res)
  );

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(build_busy && eval_busy))
    else $error("build and evaluation active together");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!build_busy && !eval_busy))
    else $error("input ready while a unit is busy");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == T_OUT))
    else $error("result beat without a finished item");

  a_valid_keep: assert property (@(posedge clk) disable iff (rst)
    !$fell(geom.valid))
    else $error("tables valid dropped");

endmodule

@@ tb/sv/perlin_turbulence_generator_test.sv @@
// self-checking testbench of the perlin turbulence generator
`timescale 1ns / 100ps

module perlin_turbulence_generator_test;
  import ptg_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam longint unsigned PARK_M = 64'd2147483647;

  typedef struct {
    logic [18:0] noise_sum;
    logic [7:0]  pixel_value;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  perlin_turbulence_generator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // register copies
  longint      r_seed;
  logic [19:0] r_freq_x, r_freq_y;
  logic [3:0]  r_octaves;
  logic        r_fractal, r_stitch;
  logic [12:0] r_tile_w, r_tile_h;

  // table copies
  int          perm_tbl [256];
  logic [31:0] grad_tbl [4][256];
  longint      lat_fx, lat_fy, lat_wx, lat_wy;
  bit          tables_built;

  pixel_res_t  pixel_q [$];
  int          errors;
  int          burst_left;
  int          idle_cycles;
  int          cyc;

  function automatic logic [15:0] unit_comp(longint c, longint unsigned n);
    longint unsigned a, lim, d;
    logic [15:0] r;
    a = (c < 0) ? -c : c;
    lim = (a * a) << 30;
    r = '0;
    if (n == 0) return '0;
    for (int b = 15; b >= 0; b--) begin
      d = 2 * (r | (16'd1 << b)) - 1;
      if (d * d * n <= lim) r = r | (16'd1 << b);
    end
    return (c < 0) ? -r : r;
  endfunction

  task automatic fit_stitch(input longint f, input longint w, output longint adj,
                            output longint width);
    longint unsigned p, lo, r, n, q;
    p = w * f;
    lo = p >> 16;
    r = p & 64'hFFFF;
    if (r == 0 || (2 * lo * r * 65536 + r * r < (lo << 32))) n = lo;
    else n = lo + 1;
    q = (n * 65536 + w / 2) / w;
    adj = (q > 64'hFFFFF) ? 64'hFFFFF : q;
    width = n;
  endtask

  task automatic rebuild_tables();
    longint s0, c0, c1, tw, th;
    longint unsigned s, n;
    int j, t;
    s0 = r_seed;
    if (s0 <= 0) s0 = -(s0 % longint'(PARK_M - 1)) + 1;
    if (s0 > longint'(PARK_M - 1)) s0 = PARK_M - 1;
    s = s0;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 256; i++) begin
        perm_tbl[i] = i;
        s = (16807 * s) % PARK_M;
        c0 = longint'(s % 512) - 256;
        s = (16807 * s) % PARK_M;
        c1 = longint'(s % 512) - 256;
        n = c0 * c0 + c1 * c1;
        grad_tbl[k][i] = {unit_comp(c1, n), unit_comp(c0, n)};
      end
    for (int i = 255; i > 0; i--) begin
      t = perm_tbl[i];
      s = (16807 * s) % PARK_M;
      j = int'(s % 256);
      perm_tbl[i] = perm_tbl[j];
      perm_tbl[j] = t;
    end
    if (r_stitch) begin
      tw = (r_tile_w == 0) ? 1 : r_tile_w;
      th = (r_tile_h == 0) ? 1 : r_tile_h;
      fit_stitch(r_freq_x, tw, lat_fx, lat_wx);
      fit_stitch(r_freq_y, th, lat_fy, lat_wy);
    end else begin
      lat_fx = r_freq_x;
      lat_fy = r_freq_y;
      lat_wx = 0;
      lat_wy = 0;
    end
    tables_built = 1'b1;
  endtask

  function automatic longint grad_dot(logic [31:0] g, longint rx, longint ry);
    return (rx * longint'($signed(g[15:0])) + ry * longint'($signed(g[31:16]))) >>> 14;
  endfunction

  function automatic longint ease(longint t);
    longint t2;
    t2 = (t * t) >>> 16;
    return (t2 * ((longint'(3) << 16) - 2 * t)) >>> 16;
  endfunction

  function automatic longint lattice_noise(int ch, longint vx, longint vy, bit st,
                                           longint wx, longint wrx, longint wy, longint wry);
    longint tx, ty, bx0, bx1, by0, by1, rx0, rx1, ry0, ry1, sx, sy, u, v, a, b;
    int i, j, iy0, iy1;
    tx = vx + (longint'(4096) << 16);
    ty = vy + (longint'(4096) << 16);
    bx0 = tx >>> 16; bx1 = bx0 + 1;
    by0 = ty >>> 16; by1 = by0 + 1;
    rx0 = tx & 16'hFFFF; rx1 = rx0 - 65536;
    ry0 = ty & 16'hFFFF; ry1 = ry0 - 65536;
    if (st) begin
      if (bx0 >= wrx) bx0 -= wx;
      if (bx1 >= wrx) bx1 -= wx;
      if (by0 >= wry) by0 -= wy;
      if (by1 >= wry) by1 -= wy;
    end
    i = perm_tbl[bx0 & 255];
    j = perm_tbl[bx1 & 255];
    iy0 = int'(by0 & 255);
    iy1 = int'(by1 & 255);
    sx = ease(rx0);
    sy = ease(ry0);
    u = grad_dot(grad_tbl[ch][perm_tbl[(i + iy0) & 255]], rx0, ry0);
    v = grad_dot(grad_tbl[ch][perm_tbl[(j + iy0) & 255]], rx1, ry0);
    a = u + ((sx * (v - u)) >>> 16);
    u = grad_dot(grad_tbl[ch][perm_tbl[(i + iy1) & 255]], rx0, ry1);
    v = grad_dot(grad_tbl[ch][perm_tbl[(j + iy1) & 255]], rx1, ry1);
    b = u + ((sx * (v - u)) >>> 16);
    return a + ((sy * (b - a)) >>> 16);
  endfunction

  function automatic pixel_res_t turbulence_pixel(logic [11:0] px, logic [11:0] py, int ch);
    pixel_res_t res;
    longint vx, vy, wx, wy, wrx, wry, sum, n, pix;
    int n_oct;
    res.noise_sum = '0;
    res.pixel_value = '0;
    if (!tables_built) return res;
    n_oct = (r_octaves > 10) ? 10 : r_octaves;
    vx = longint'(px) * lat_fx;
    vy = longint'(py) * lat_fy;
    wx = lat_wx; wy = lat_wy;
    wrx = 4096 + wx; wry = 4096 + wy;
    sum = 0;
    for (int k = 0; k < n_oct; k++) begin
      n = lattice_noise(ch, vx, vy, r_stitch, wx, wrx, wy, wry);
      if (!r_fractal && n < 0) n = -n;
      sum += n >>> k;
      vx <<= 1; vy <<= 1;
      wx *= 2; wy *= 2;
      wrx = 2 * wrx - 4096;
      wry = 2 * wry - 4096;
    end
    if (sum > 262143) sum = 262143;
    if (sum < -262144) sum = -262144;
    if (r_fractal) pix = (sum * 255 + 255 * 65536) >>> 17;
    else pix = (sum * 255) >>> 16;
    if (pix < 0) pix = 0;
    if (pix > 255) pix = 255;
    res.noise_sum = sum[18:0];
    res.pixel_value = pix[7:0];
    return res;
  endfunction

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SEED:    r_seed = longint'($signed(value));
      CFG_FREQ_X:  r_freq_x = value[19:0];
      CFG_FREQ_Y:  r_freq_y = value[19:0];
      CFG_OCTAVES: r_octaves = value[3:0];
      CFG_FRACTAL: r_fractal = value[0];
      CFG_STITCH:  r_stitch = value[0];
      CFG_TILE_W:  r_tile_w = value[12:0];
      CFG_TILE_H:  r_tile_h = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input op_t op, input logic [11:0] px, input logic [11:0] py,
                           input logic [1:0] ch);
    pixel_res_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'b0, ch, py, px};
    do @(posedge clk); while (!s_tready);
    if (op == OP_BUILD) begin
      rebuild_tables();
      res.noise_sum = '0;
      res.pixel_value = '0;
    end else begin
      res = turbulence_pixel(px, py, ch);
    end
    pixel_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++)
      send_item(OP_EVAL, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                2'($urandom_range(0, 3)));
  endtask

  task automatic send_corner_pixels();
    for (int c = 0; c < 4; c++) begin
      send_item(OP_EVAL, 12'd0, 12'd0, 2'(c));
      send_item(OP_EVAL, 12'hFFF, 12'hFFF, 2'(c));
    end
    send_item(OP_EVAL, 12'hFFF, 12'd0, 2'd1);
  endtask

  task automatic finish_burst();
    s_tvalid <= 1'b0;
    burst_left = 0;
    wait_drained();
  endtask

  task automatic test_pixel_before_build();
    send_item(OP_EVAL, 12'd17, 12'd99, 2'd3);
    send_item(OP_EVAL, 12'hFFF, 12'hFFF, 2'd0);
    finish_burst();
  endtask

  task automatic test_reset_settings();
    send_item(OP_BUILD, 12'd0, 12'd0, 2'd0);
    send_corner_pixels();
    finish_burst();
  endtask

  task automatic test_octave_limit_turbulence();
    write_reg(CFG_OCTAVES, 32'd15);
    write_reg(CFG_FRACTAL, 32'd0);
    send_corner_pixels();
    finish_burst();
    write_reg(CFG_OCTAVES, 32'd0);
    send_item(OP_EVAL, 12'd5, 12'd7, 2'd2);
    finish_burst();
  endtask

  task automatic test_stitch_extremes();
    write_reg(CFG_SEED, 32'h8000_0000);
    write_reg(CFG_FREQ_X, 32'hFFFFF);
    write_reg(CFG_FREQ_Y, 32'd0);
    write_reg(CFG_OCTAVES, 32'd10);
    write_reg(CFG_FRACTAL, 32'd1);
    write_reg(CFG_STITCH, 32'd1);
    write_reg(CFG_TILE_W, 32'd0);
    write_reg(CFG_TILE_H, 32'd4096);
    send_item(OP_BUILD, 12'hFFF, 12'hFFF, 2'd3);
    send_corner_pixels();
    finish_burst();
    // stitch dropped without a rebuild keeps the latched geometry
    write_reg(CFG_STITCH, 32'd0);
    send_corner_pixels();
    finish_burst();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_SEED, (ph == 0) ? 32'h7FFF_FFFF : $urandom());
      write_reg(CFG_FREQ_X, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'hFFFFF)
                                                      : $urandom_range(0, 8000));
      write_reg(CFG_FREQ_Y, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32'hFFFFF)
                                                      : $urandom_range(0, 8000));
      write_reg(CFG_OCTAVES, $urandom_range(0, 15));
      write_reg(CFG_FRACTAL, $urandom_range(0, 1));
      write_reg(CFG_STITCH, (ph == 1) ? 32'd1 : $urandom_range(0, 1));
      write_reg(CFG_TILE_W, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 300));
      write_reg(CFG_TILE_H, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 300));
      send_item(OP_BUILD, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                2'($urandom_range(0, 3)));
      send_random_pixels(120);
      finish_burst();
      write_reg(CFG_OCTAVES, $urandom_range(0, 15));
      write_reg(CFG_FRACTAL, $urandom_range(0, 1));
      write_reg(CFG_STITCH, $urandom_range(0, 1));
      send_random_pixels(115);
      finish_burst();
    end
  endtask

  // result side: the stall pattern rotates through four modes
  always @(negedge clk) begin
    cyc <= cyc + 1;
    case ((cyc >> 9) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((cyc % 5) < 3);
      default: m_tready <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata[18:0] !== pixel_q[0].noise_sum) begin
          $display("%0t: noise_sum expected %h actual %h", $time,
                   pixel_q[0].noise_sum, m_tdata[18:0]);
          errors++;
        end
        if (m_tdata[26:19] !== pixel_q[0].pixel_value) begin
          $display("%0t: pixel_value expected %h actual %h", $time,
                   pixel_q[0].pixel_value, m_tdata[26:19]);
          errors++;
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[perlin_turbulence_generator] ERROR");
      $finish;
    end
  end

  initial begin
    cyc = 0;
    errors = 0;
    burst_left = 0;
    idle_cycles = 0;
    tables_built = 1'b0;
    r_seed = 0;
    r_freq_x = 20'd655;
    r_freq_y = 20'd655;
    r_octaves = 4'd1;
    r_fractal = 1'b1;
    r_stitch = 1'b0;
    r_tile_w = 13'd256;
    r_tile_h = 13'd256;
    lat_fx = 0; lat_fy = 0; lat_wx = 0; lat_wy = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_pixel_before_build();
    test_reset_settings();
    test_octave_limit_turbulence();
    test_stitch_extremes();
    test_random_phases();
    repeat (200) @(negedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("[perlin_turbulence_generator] OK");
    end else begin
      $display("[perlin_turbulence_generator] ERROR");
    end
    $finish;
  end

endmodule
